// ===== rtl/pfn_pkg.sv =====
// shared types and constants for the polygon fan normal block
`default_nettype none
package pfn_pkg;
  localparam int CW = 16;
  localparam int NW = 24;
  localparam int EW = 24;
  localparam int FW = 3;
  localparam int DW = CW + 1;      // edge difference width
  localparam int PW = 2 * DW + 1;  // cross component width
  localparam int MW = 31;          // normalized magnitude width

  typedef struct packed {
    logic [CW-1:0] coord_x;
    logic [CW-1:0] coord_y;
    logic [CW-1:0] coord_z;
    logic [NW-1:0] node_id;
    logic [EW-1:0] element_id;
    logic [FW-1:0] face_number;
    logic          last_vertex;
  } in_item_t;

  typedef struct packed {
    logic [NW-1:0] node_a;
    logic [NW-1:0] node_b;
    logic [NW-1:0] node_c;
    logic [15:0]   normal_x;
    logic [15:0]   normal_y;
    logic [15:0]   normal_z;
    logic          degenerate;
    logic [EW-1:0] owner_element;
    logic [FW-1:0] owner_face;
    logic          last_triangle;
  } out_item_t;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_MUL   = 8'b00000010,
    S_NORM  = 8'b00000100,
    S_SQR   = 8'b00001000,
    S_SQRT  = 8'b00010000,
    S_DIV   = 8'b00100000,
    S_OUT   = 8'b01000000,
    S_DEGEN = 8'b10000000
  } state_t;
endpackage
`default_nettype wire

// ===== rtl/pfn_if.sv =====
// valid/ready channel carrying one payload
`default_nettype none
interface pfn_if #(parameter type T = logic) (input wire logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/polygon_fan_flat_normal_top.sv =====
// polygon fan triangulation with per-triangle unit normal, serial arithmetic
// steps from a closing vertex to its triangle; a degenerate one goes from the first normalize check to output
// (6 serial multiplies, the normalizing shifts, 3 squares,
// a root, 3 divides, an output step)
// one triangle in flight; the first two vertices of a face are only stored
// the output register frees the input side once a triangle is loaded into it
// reset: synchronous active-low rst_n clears control, face state and the limit
`default_nettype none
module polygon_fan_flat_normal_top import pfn_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic signed [CW-1:0]  in_coord_x,
  input  wire logic signed [CW-1:0]  in_coord_y,
  input  wire logic signed [CW-1:0]  in_coord_z,
  input  wire logic [NW-1:0]         in_node_id,
  input  wire logic [EW-1:0]         in_element_id,
  input  wire logic [FW-1:0]         in_face_number,
  input  wire logic                  in_last_vertex,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [NW-1:0]              out_node_a,
  output logic [NW-1:0]              out_node_b,
  output logic [NW-1:0]              out_node_c,
  output logic signed [15:0]         out_normal_x,
  output logic signed [15:0]         out_normal_y,
  output logic signed [15:0]         out_normal_z,
  output logic                       out_degenerate,
  output logic [EW-1:0]              out_owner_element,
  output logic [FW-1:0]              out_owner_face,
  output logic                       out_last_triangle,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [15:0]           cfg_data
);
  pfn_if #(.T(in_item_t)) in_ch (.clk(clk));
  pfn_if #(.T(out_item_t)) out_ch (.clk(clk));

  assign in_ch.valid = in_valid;
  assign in_ready = in_ch.ready;
  assign in_ch.data = '{coord_x: in_coord_x, coord_y: in_coord_y, coord_z: in_coord_z,
                        node_id: in_node_id, element_id: in_element_id,
                        face_number: in_face_number, last_vertex: in_last_vertex};
  assign out_valid = out_ch.valid;
  assign out_ch.ready = out_ready;
  assign out_node_a = out_ch.data.node_a;
  assign out_node_b = out_ch.data.node_b;
  assign out_node_c = out_ch.data.node_c;
  assign out_normal_x = out_ch.data.normal_x;
  assign out_normal_y = out_ch.data.normal_y;
  assign out_normal_z = out_ch.data.normal_z;
  assign out_degenerate = out_ch.data.degenerate;
  assign out_owner_element = out_ch.data.owner_element;
  assign out_owner_face = out_ch.data.owner_face;
  assign out_last_triangle = out_ch.data.last_triangle;

  // state
  state_t        st_r, st_nxt;
  logic [15:0]   limit_r;
  logic [CW-1:0] ca_r [3];
  logic [CW-1:0] pb_r [3];
  logic [NW-1:0] cnode_r, pnode_r;
  logic [1:0]    seen_r;
  in_item_t      cur_r;
  logic [DW-1:0] e1_r [3];
  logic [DW-1:0] e2_r [3];
  logic [PW-1:0] cr_r [3];
  logic [63:0]   m_r [3];
  logic [63:0]   sum_r;
  logic [31:0]   root_r;
  logic [15:0]   nrm_r [3];
  logic [2:0]    step_r;
  logic          half_r;
  logic          launch_r, launch_nxt;
  logic          norm_first_r;
  out_item_t     obuf_r;
  logic          ovld_r;

  assign cfg_ready = 1'b1;
  assign in_ch.ready = (st_r == S_IDLE);
  logic acc;
  assign acc = in_ch.valid && in_ch.ready;

  // serial unit operand muxing
  logic [31:0] ma, mb;
  logic        mdone, sdone, ddone;
  logic [63:0] mprod;
  logic [31:0] sroot;
  logic [47:0] dquo;
  logic [1:0]  ix1, ix2;

  always_comb begin
    ix1 = 2'd1; ix2 = 2'd2;
    case (step_r)
      3'd0: begin ix1 = 2'd1; ix2 = 2'd2; end
      3'd1: begin ix1 = 2'd2; ix2 = 2'd0; end
      3'd2: begin ix1 = 2'd0; ix2 = 2'd1; end
      default: begin ix1 = 2'd1; ix2 = 2'd2; end
    endcase
  end

  logic [DW-1:0] opa, opb;
  logic          negp;
  always_comb begin
    if (st_r == S_MUL) begin
      opa = half_r ? e1_r[ix2] : e1_r[ix1];
      opb = half_r ? e2_r[ix1] : e2_r[ix2];
      ma = {{(32-DW){1'b0}}, opa[DW-1] ? -opa : opa};
      mb = {{(32-DW){1'b0}}, opb[DW-1] ? -opb : opb};
      negp = opa[DW-1] ^ opb[DW-1];
    end else begin
      opa = '0; opb = '0; negp = 1'b0;
      ma = m_r[step_r[1:0]][31:0];
      mb = m_r[step_r[1:0]][31:0];
    end
  end

  logic [PW-1:0] sprod;
  assign sprod = negp ? -mprod[PW-1:0] : mprod[PW-1:0];

  pfn_serial_mul u_mul (.clk(clk), .rst_n(rst_n),
    .start(launch_r && (st_r == S_MUL || st_r == S_SQR)),
    .a(ma), .b(mb), .done(mdone), .prod(mprod));
  pfn_isqrt u_sqrt (.clk(clk), .rst_n(rst_n),
    .start(launch_r && st_r == S_SQRT), .x(sum_r), .done(sdone), .root(sroot));
  pfn_divider u_div (.clk(clk), .rst_n(rst_n),
    .start(launch_r && st_r == S_DIV),
    .num({2'b0, m_r[step_r[1:0]][30:0], 15'd0} + {16'd0, 1'b0, root_r[31:1]}),
    .den(root_r), .done(ddone), .quo(dquo));

  // magnitudes of the cross product, largest magnitude and small-triangle test
  logic [PW-1:0] mag [3];
  logic [PW-1:0] mx;
  logic          tiny;
  logic [63:0]   ssmall;
  always_comb begin
    for (int i = 0; i < 3; i++) mag[i] = cr_r[i][PW-1] ? -cr_r[i] : cr_r[i];
    mx = mag[0];
    if (mag[1] > mx) mx = mag[1];
    if (mag[2] > mx) mx = mag[2];
    tiny = (mag[0] <= PW'(255)) && (mag[1] <= PW'(255)) && (mag[2] <= PW'(255));
    ssmall = 64'({8'd0, mag[0][7:0]} * {8'd0, mag[0][7:0]})
           + 64'({8'd0, mag[1][7:0]} * {8'd0, mag[1][7:0]})
           + 64'({8'd0, mag[2][7:0]} * {8'd0, mag[2][7:0]});
  end

  logic [15:0] qsat;
  assign qsat = (dquo > 48'd32767) ? 16'd32767 : dquo[15:0];

  // sequencer
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE:  if (acc && seen_r == 2'd2) st_nxt = S_MUL;
      S_MUL:   if (mdone && half_r && step_r == 3'd2) st_nxt = S_NORM;
      S_NORM: begin
        if (norm_first_r) begin
          if (tiny && ((ssmall <= {48'd0, limit_r}) || ssmall == 64'd0)) st_nxt = S_DEGEN;
          else st_nxt = S_NORM;
        end else if (m_r[0][63:30] == 34'd0 && m_r[1][63:30] == 34'd0
                 && m_r[2][63:30] == 34'd0) st_nxt = S_NORM;
        else if (m_r[0][63:31] == 33'd0 && m_r[1][63:31] == 33'd0
                 && m_r[2][63:31] == 33'd0) st_nxt = S_SQR;
        else st_nxt = S_NORM;
      end
      S_SQR:   if (mdone && step_r == 3'd2) st_nxt = S_SQRT;
      S_SQRT:  if (sdone) st_nxt = S_DIV;
      S_DIV:   if (ddone && step_r == 3'd2) st_nxt = S_OUT;
      S_OUT:   if (!ovld_r) st_nxt = S_IDLE;
      S_DEGEN: if (!ovld_r) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  // start pulse for the serial units
  assign launch_nxt = (acc && seen_r == 2'd2)
                   || (st_r == S_MUL && mdone && (!half_r || step_r != 3'd2))
                   || (st_r == S_NORM && st_nxt == S_SQR)
                   || (st_r == S_SQR && mdone)
                   || (st_r == S_SQRT && sdone)
                   || (st_r == S_DIV && ddone && step_r != 3'd2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      limit_r <= '0;
      seen_r <= '0;
      ovld_r <= 1'b0;
      launch_r <= 1'b0;
      step_r <= '0;
      half_r <= 1'b0;
      cnode_r <= '0;
      pnode_r <= '0;
      norm_first_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        ca_r[i] <= '0;
        pb_r[i] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      launch_r <= launch_nxt;
      if (cfg_valid && cfg_ready) limit_r <= cfg_data;
      if (out_ch.valid && out_ch.ready) ovld_r <= 1'b0;
      // vertex acceptance and face bookkeeping
      if (acc) begin
        cur_r <= in_ch.data;
        if (seen_r == 2'd0) begin
          ca_r[0] <= in_ch.data.coord_x; ca_r[1] <= in_ch.data.coord_y;
          ca_r[2] <= in_ch.data.coord_z; cnode_r <= in_ch.data.node_id;
          seen_r <= in_ch.data.last_vertex ? 2'd0 : 2'd1;
        end else if (seen_r == 2'd1) begin
          pb_r[0] <= in_ch.data.coord_x; pb_r[1] <= in_ch.data.coord_y;
          pb_r[2] <= in_ch.data.coord_z; pnode_r <= in_ch.data.node_id;
          seen_r <= in_ch.data.last_vertex ? 2'd0 : 2'd2;
        end else begin
          e1_r[0] <= DW'($signed(pb_r[0])) - DW'($signed(ca_r[0]));
          e1_r[1] <= DW'($signed(pb_r[1])) - DW'($signed(ca_r[1]));
          e1_r[2] <= DW'($signed(pb_r[2])) - DW'($signed(ca_r[2]));
          e2_r[0] <= DW'($signed(in_ch.data.coord_x)) - DW'($signed(ca_r[0]));
          e2_r[1] <= DW'($signed(in_ch.data.coord_y)) - DW'($signed(ca_r[1]));
          e2_r[2] <= DW'($signed(in_ch.data.coord_z)) - DW'($signed(ca_r[2]));
          step_r <= '0;
          half_r <= 1'b0;
          if (in_ch.data.last_vertex) seen_r <= 2'd0;
        end
      end
      // cross products: two serial products per component
      if (st_r == S_MUL && mdone) begin
        if (!half_r) begin
          cr_r[step_r[1:0]] <= sprod;
          half_r <= 1'b1;
        end else begin
          cr_r[step_r[1:0]] <= cr_r[step_r[1:0]] - sprod;
          half_r <= 1'b0;
          if (step_r != 3'd2) begin
            step_r <= step_r + 3'd1;
          end else begin
            norm_first_r <= 1'b1;
          end
        end
      end
      // normalize magnitudes one shift per cycle
      if (st_r == S_NORM) begin
        norm_first_r <= 1'b0;
        if (norm_first_r) begin
          for (int i = 0; i < 3; i++) m_r[i] <= 64'(mag[i]);
        end else if (st_nxt == S_NORM) begin
          if (m_r[0][63:31] == 33'd0 && m_r[1][63:31] == 33'd0 && m_r[2][63:31] == 33'd0)
            for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] << 1;
          else
            for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] >> 1;
        end
        if (st_nxt == S_SQR) begin
          step_r <= '0;
          sum_r <= '0;
        end
      end
      // sum of squares
      if (st_r == S_SQR && mdone) begin
        sum_r <= sum_r + mprod;
        if (step_r != 3'd2) step_r <= step_r + 3'd1;
      end
      if (st_r == S_SQRT && sdone) begin
        root_r <= sroot;
        step_r <= '0;
      end
      // per-component divide with saturation and sign
      if (st_r == S_DIV && ddone) begin
        nrm_r[step_r[1:0]] <= cr_r[step_r[1:0]][PW-1] ? -qsat : qsat;
        if (step_r != 3'd2) step_r <= step_r + 3'd1;
      end
      // result register
      if ((st_r == S_OUT || st_r == S_DEGEN) && !ovld_r) begin
        ovld_r <= 1'b1;
        obuf_r.node_a <= cnode_r;
        obuf_r.node_b <= pnode_r;
        obuf_r.node_c <= cur_r.node_id;
        obuf_r.degenerate <= (st_r == S_DEGEN);
        obuf_r.normal_x <= (st_r == S_DEGEN) ? 16'd0 : nrm_r[0];
        obuf_r.normal_y <= (st_r == S_DEGEN) ? 16'd0 : nrm_r[1];
        obuf_r.normal_z <= (st_r == S_DEGEN) ? 16'd32767 : nrm_r[2];
        obuf_r.owner_element <= cur_r.element_id;
        obuf_r.owner_face <= cur_r.face_number;
        obuf_r.last_triangle <= cur_r.last_vertex;
        pb_r[0] <= cur_r.coord_x; pb_r[1] <= cur_r.coord_y; pb_r[2] <= cur_r.coord_z;
        pnode_r <= cur_r.node_id;
      end
    end
  end

  assign out_ch.valid = ovld_r;
  assign out_ch.data = obuf_r;
endmodule
`default_nettype wire

// ===== rtl/pfn_serial_mul.sv =====
// shift-add multiplier, one multiplier bit per cycle, unsigned operands
`default_nettype none
module pfn_serial_mul import pfn_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [31:0]     a,
  input  wire logic [31:0]     b,
  output logic                 done,
  output logic [63:0]          prod
);
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] mcand_r, mcand_nxt;
  logic [31:0] mplier_r, mplier_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;

  // one partial product per cycle
  always_comb begin
    acc_nxt = acc_r;
    mcand_nxt = mcand_r;
    mplier_nxt = mplier_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      acc_nxt = '0;
      mcand_nxt = {32'd0, a};
      mplier_nxt = b;
      cnt_nxt = 6'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (mplier_r[0]) acc_nxt = acc_r + mcand_r;
      mcand_nxt = {mcand_r[62:0], 1'b0};
      mplier_nxt = {1'b0, mplier_r[31:1]};
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd31) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    mcand_r <= mcand_nxt;
    mplier_r <= mplier_nxt;
  end

  assign done = busy_r && (cnt_r == 6'd31);
  assign prod = acc_nxt;
endmodule
`default_nettype wire

// ===== rtl/pfn_isqrt.sv =====
// bit-serial integer square root, one result bit per cycle
`default_nettype none
module pfn_isqrt import pfn_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] x,
  output logic             done,
  output logic [31:0]      root
);
  logic [63:0] rem_r, rem_nxt;
  logic [63:0] res_r, res_nxt;
  logic [63:0] bit_r, bit_nxt;
  logic        busy_r, busy_nxt;
  logic [63:0] trial;

  // classic digit-by-digit root over 32 steps
  always_comb begin
    rem_nxt = rem_r;
    res_nxt = res_r;
    bit_nxt = bit_r;
    busy_nxt = busy_r;
    trial = res_r + bit_r;
    if (start) begin
      rem_nxt = x;
      res_nxt = '0;
      bit_nxt = 64'd1 << 62;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_r >= trial) begin
        rem_nxt = rem_r - trial;
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r[0]) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    rem_r <= rem_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
  end

  assign done = busy_r && bit_r[0];
  assign root = res_nxt[31:0];
endmodule
`default_nettype wire

// ===== rtl/pfn_divider.sv =====
// restoring divider, one quotient bit per cycle
`default_nettype none
module pfn_divider import pfn_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [47:0] num,
  input  wire logic [31:0] den,
  output logic             done,
  output logic [47:0]      quo
);
  logic [47:0] q_r, q_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [32:0] sh;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    sh = {rem_r[31:0], q_r[47]};
    if (start) begin
      q_nxt = num;
      rem_nxt = '0;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (sh >= {1'b0, den}) begin
        rem_nxt = sh - {1'b0, den};
        q_nxt = {q_r[46:0], 1'b1};
      end else begin
        rem_nxt = sh;
        q_nxt = {q_r[46:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd47) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign done = busy_r && (cnt_r == 6'd47);
  assign quo = q_nxt;
endmodule
`default_nettype wire

// ===== tb/sv/polygon_fan_flat_normal_top_tb.sv =====
// self-checking testbench for the polygon fan normal block
`timescale 1ns / 1ps
`default_nettype none

import pfn_pkg::*;

// expected triangle store plus its own copy of the fan state
class fan_scoreboard;
  out_item_t      pending_tris[$];
  logic [15:0]    limit_reg;
  longint         center_xyz[3];
  logic [NW-1:0]  center_id;
  longint         prev_xyz[3];
  logic [NW-1:0]  prev_id;
  int unsigned    seen;
  int unsigned    errors;
  int unsigned    tris_checked;
  int unsigned    degen_checked;
  int unsigned    vertices_in;

  function new();
    limit_reg = '0;
    center_id = '0;
    prev_id = '0;
    seen = 0;
    errors = 0;
    tris_checked = 0;
    degen_checked = 0;
    vertices_in = 0;
    for (int i = 0; i < 3; i++) begin
      center_xyz[i] = 0;
      prev_xyz[i] = 0;
    end
  endfunction

  function void set_limit(logic [15:0] value);
    limit_reg = value;
  endfunction

  // integer square root, floor
  function longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // unit normal of (b-a) x (c-a) in Q1.15, returns degenerate flag
  function bit unit_normal(longint a[3], longint b[3], longint c[3],
                           output logic [15:0] nrm[3]);
    longint          e1[3];
    longint          e2[3];
    longint          cr[3];
    longint unsigned mag[3];
    longint unsigned mx;
    longint unsigned sq;
    longint unsigned root;
    longint unsigned q;
    for (int i = 0; i < 3; i++) begin
      e1[i] = b[i] - a[i];
      e2[i] = c[i] - a[i];
    end
    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
    cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
    for (int i = 0; i < 3; i++) mag[i] = (cr[i] < 0) ? -cr[i] : cr[i];
    if (mag[0] <= 255 && mag[1] <= 255 && mag[2] <= 255) begin
      sq = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
      if (sq <= limit_reg || sq == 0) begin
        nrm[0] = 16'd0;
        nrm[1] = 16'd0;
        nrm[2] = 16'd32767;
        return 1'b1;
      end
    end
    mx = mag[0];
    if (mag[1] > mx) mx = mag[1];
    if (mag[2] > mx) mx = mag[2];
    while (mx >= (64'd1 << 31)) begin
      mx = mx >> 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
    end
    while (mx < (64'd1 << 30)) begin
      mx = mx << 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
    end
    sq = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
    root = int_sqrt(sq);
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << 15) + (root >> 1)) / root;
      if (q > 32767) q = 32767;
      nrm[i] = (cr[i] < 0) ? 16'(17'h10000 - q) : 16'(q);
    end
    return 1'b0;
  endfunction

  // accepted vertex: advance the fan, queue a triangle when one closes
  function void note_vertex(in_item_t v);
    longint      cur[3];
    out_item_t   exp_item;
    logic [15:0] nrm[3];
    cur[0] = longint'($signed(v.coord_x));
    cur[1] = longint'($signed(v.coord_y));
    cur[2] = longint'($signed(v.coord_z));
    vertices_in++;
    if (seen == 0) begin
      center_xyz = cur;
      center_id = v.node_id;
      seen = 1;
    end else if (seen == 1) begin
      prev_xyz = cur;
      prev_id = v.node_id;
      seen = 2;
    end else begin
      exp_item.node_a = center_id;
      exp_item.node_b = prev_id;
      exp_item.node_c = v.node_id;
      exp_item.degenerate = unit_normal(center_xyz, prev_xyz, cur, nrm);
      exp_item.normal_x = nrm[0];
      exp_item.normal_y = nrm[1];
      exp_item.normal_z = nrm[2];
      exp_item.owner_element = v.element_id;
      exp_item.owner_face = v.face_number;
      exp_item.last_triangle = v.last_vertex;
      pending_tris = {pending_tris, exp_item};
      prev_xyz = cur;
      prev_id = v.node_id;
    end
    if (v.last_vertex) seen = 0;
  endfunction

  function void field_check(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  // accepted triangle against the oldest expectation
  function void check_triangle(out_item_t got);
    out_item_t want;
    if (pending_tris.size() == 0) begin
      errors++;
      $display("%0t: unexpected triangle expected none actual %h", $time, got);
      return;
    end
    want = pending_tris.pop_front();
    tris_checked++;
    if (want.degenerate) degen_checked++;
    field_check("node_a", want.node_a, got.node_a);
    field_check("node_b", want.node_b, got.node_b);
    field_check("node_c", want.node_c, got.node_c);
    field_check("normal_x", want.normal_x, got.normal_x);
    field_check("normal_y", want.normal_y, got.normal_y);
    field_check("normal_z", want.normal_z, got.normal_z);
    field_check("degenerate", want.degenerate, got.degenerate);
    field_check("owner_element", want.owner_element, got.owner_element);
    field_check("owner_face", want.owner_face, got.owner_face);
    field_check("last_triangle", want.last_triangle, got.last_triangle);
  endfunction
endclass

module polygon_fan_flat_normal_top_tb;
  import pfn_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 700;

  logic clk;
  logic rst_n;

  pfn_if #(in_item_t)    vert_ch (clk);
  pfn_if #(out_item_t)   tri_ch (clk);
  pfn_if #(logic [15:0]) cfg_ch (clk);

  fan_scoreboard sb;
  int unsigned   idle_cycles;
  bit            hold_req;
  bit            no_idle;
  int unsigned   long_holds;

  polygon_fan_flat_normal_top u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (vert_ch.valid),
    .in_ready          (vert_ch.ready),
    .in_coord_x        (vert_ch.data.coord_x),
    .in_coord_y        (vert_ch.data.coord_y),
    .in_coord_z        (vert_ch.data.coord_z),
    .in_node_id        (vert_ch.data.node_id),
    .in_element_id     (vert_ch.data.element_id),
    .in_face_number    (vert_ch.data.face_number),
    .in_last_vertex    (vert_ch.data.last_vertex),
    .out_valid         (tri_ch.valid),
    .out_ready         (tri_ch.ready),
    .out_node_a        (tri_ch.data.node_a),
    .out_node_b        (tri_ch.data.node_b),
    .out_node_c        (tri_ch.data.node_c),
    .out_normal_x      (tri_ch.data.normal_x),
    .out_normal_y      (tri_ch.data.normal_y),
    .out_normal_z      (tri_ch.data.normal_z),
    .out_degenerate    (tri_ch.data.degenerate),
    .out_owner_element (tri_ch.data.owner_element),
    .out_owner_face    (tri_ch.data.owner_face),
    .out_last_triangle (tri_ch.data.last_triangle),
    .cfg_valid         (cfg_ch.valid),
    .cfg_ready         (cfg_ch.ready),
    .cfg_data          (cfg_ch.data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned gap_len();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(20, 4);
    return $urandom_range(200, 50);
  endfunction

  // monitors and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (vert_ch.valid && vert_ch.ready) sb.note_vertex(vert_ch.data);
      if (tri_ch.valid && tri_ch.ready) sb.check_triangle(tri_ch.data);
      if (cfg_ch.valid && cfg_ch.ready) sb.set_limit(cfg_ch.data);
      if ((vert_ch.valid && vert_ch.ready) || (tri_ch.valid && tri_ch.ready)
          || (cfg_ch.valid && cfg_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // receiver: random stalls, and a long hold-off on request
  initial begin
    tri_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        tri_ch.ready = 1'b0;
        repeat (1500) @(negedge clk);
        hold_req = 1'b0;
        long_holds++;
      end
      if (no_idle) begin
        tri_ch.ready = 1'b1;
      end else begin
        tri_ch.ready = ($urandom_range(99) < 70);
        if (!tri_ch.ready) repeat (gap_len()) @(negedge clk);
      end
    end
  end

  // one vertex, held until accepted; valid stays high for a back-to-back vertex
  task automatic send_vertex(in_item_t v);
    int unsigned g;
    g = gap_len();
    if (g != 0) begin
      vert_ch.valid = 1'b0;
      repeat (g) @(negedge clk);
    end
    vert_ch.data = v;
    vert_ch.valid = 1'b1;
    do @(posedge clk); while (!vert_ch.ready);
    @(negedge clk);
  endtask

  task automatic write_limit(logic [15:0] value);
    cfg_ch.data = value;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // sender pause until every expected triangle is out, plus block latency
  task automatic wait_quiet();
    vert_ch.valid = 1'b0;
    while (sb.pending_tris.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic in_item_t make_vertex(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                                           logic [NW-1:0] id, logic [EW-1:0] elem,
                                           logic [FW-1:0] face, logic last);
    in_item_t v;
    v.coord_x = x;
    v.coord_y = y;
    v.coord_z = z;
    v.node_id = id;
    v.element_id = elem;
    v.face_number = face;
    v.last_vertex = last;
    return v;
  endfunction

  // random face; spread picks how far vertices sit from a base point
  task automatic send_face(int unsigned count, int unsigned spread);
    logic [EW-1:0] elem;
    logic [FW-1:0] face;
    int            base[3];
    int            pt[3];
    bit            mixed;
    in_item_t      v;
    elem = EW'($urandom());
    face = FW'($urandom_range(7));
    mixed = ($urandom_range(9) == 0);
    for (int k = 0; k < 3; k++) base[k] = int'($signed(16'($urandom())));
    for (int n = 0; n < count; n++) begin
      for (int k = 0; k < 3; k++) begin
        if (spread == 0) pt[k] = int'($signed(16'($urandom())));
        else pt[k] = base[k] + $signed($urandom_range(2 * spread)) - int'(spread);
      end
      // occasional repeated or collinear vertex
      if (n >= 2 && $urandom_range(15) == 0) begin
        for (int k = 0; k < 3; k++) pt[k] = base[k];
      end
      if (mixed) begin
        elem = EW'($urandom());
        face = FW'($urandom_range(7));
      end
      v = make_vertex(16'(pt[0]), 16'(pt[1]), 16'(pt[2]), NW'($urandom()), elem, face,
                      n == count - 1);
      send_vertex(v);
    end
  endtask

  task automatic random_faces(int unsigned target);
    int unsigned sent;
    int unsigned count;
    int unsigned r;
    int unsigned spread;
    sent = 0;
    while (sent < target) begin
      r = $urandom_range(99);
      // broken faces now and then, mostly full fans
      if (r < 10) count = $urandom_range(2, 1);
      else if (r < 80) count = $urandom_range(5, 3);
      else count = $urandom_range(10, 6);
      r = $urandom_range(99);
      if (r < 40) spread = 0;
      else if (r < 70) spread = $urandom_range(3000, 100);
      else if (r < 90) spread = $urandom_range(16, 1);
      else spread = $urandom_range(60, 17);
      send_face(count, spread);
      sent += count;
    end
  endtask

  task automatic directed_faces();
    // extreme coordinates and node ids, face number past the used range
    send_vertex(make_vertex(16'h8000, 16'h8000, 16'h8000, '0, '0, 3'd0, 1'b0));
    send_vertex(make_vertex(16'h7fff, 16'h8000, 16'h8000, '1, '1, 3'd6, 1'b0));
    send_vertex(make_vertex(16'h8000, 16'h7fff, 16'h8000, 24'h5a5a5a, '1, 3'd7, 1'b0));
    send_vertex(make_vertex(16'h8000, 16'h8000, 16'h7fff, '1, 24'h123456, 3'd5, 1'b1));
    // lone vertex and a two-vertex face give nothing
    send_vertex(make_vertex(16'h0100, 16'h0200, 16'h0300, 24'd1, 24'd2, 3'd1, 1'b1));
    send_vertex(make_vertex(16'h0100, 16'h0200, 16'h0300, 24'd1, 24'd2, 3'd1, 1'b0));
    send_vertex(make_vertex(16'h0400, 16'h0200, 16'h0300, 24'd3, 24'd2, 3'd1, 1'b1));
    // zero-area triangle from repeated vertices, then a collinear one
    send_vertex(make_vertex(16'h0010, 16'h0010, 16'h0010, 24'd7, 24'd9, 3'd2, 1'b0));
    send_vertex(make_vertex(16'h0010, 16'h0010, 16'h0010, 24'd8, 24'd9, 3'd2, 1'b0));
    send_vertex(make_vertex(16'h0010, 16'h0010, 16'h0010, 24'd9, 24'd9, 3'd2, 1'b0));
    send_vertex(make_vertex(16'h0020, 16'h0020, 16'h0020, 24'd10, 24'd9, 3'd2, 1'b1));
    // tiny triangle, cross of a single LSB, owners change mid-face
    send_vertex(make_vertex(16'h0000, 16'h0000, 16'h0000, 24'd11, 24'd20, 3'd3, 1'b0));
    send_vertex(make_vertex(16'h0001, 16'h0000, 16'h0000, 24'd12, 24'd21, 3'd4, 1'b0));
    send_vertex(make_vertex(16'h0000, 16'h0001, 16'h0000, 24'd13, 24'd22, 3'd5, 1'b0));
    send_vertex(make_vertex(16'hffff, 16'hffff, 16'h0000, 24'd14, 24'd23, 3'd0, 1'b1));
    // axis-aligned right triangles with normals along +x, +y and -z
    send_vertex(make_vertex(16'h0000, 16'h0000, 16'h0000, 24'd15, 24'd30, 3'd1, 1'b0));
    send_vertex(make_vertex(16'h0000, 16'h0100, 16'h0000, 24'd16, 24'd30, 3'd1, 1'b0));
    send_vertex(make_vertex(16'h0000, 16'h0000, 16'h0100, 24'd17, 24'd30, 3'd1, 1'b0));
    send_vertex(make_vertex(16'h0100, 16'h0000, 16'h0000, 24'd18, 24'd30, 3'd1, 1'b0));
    send_vertex(make_vertex(16'h0000, 16'hff00, 16'h0000, 24'd19, 24'd30, 3'd1, 1'b1));
  endtask

  // main sequence
  initial begin
    logic [15:0] limits[4];
    sb = new();
    idle_cycles = 0;
    hold_req = 1'b0;
    no_idle = 1'b0;
    long_holds = 0;
    rst_n = 1'b0;
    vert_ch.valid = 1'b0;
    vert_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    limits[0] = 16'd0;
    limits[1] = 16'd65535;
    limits[2] = 16'($urandom_range(2000, 2));
    limits[3] = 16'd1;

    for (int phase = 0; phase < 4; phase++) begin
      write_limit(limits[phase]);
      no_idle = (phase == 2);
      if (phase == 0) directed_faces();
      if (phase == 1) begin
        directed_faces();
        // receiver holds off while vertices keep coming
        hold_req = 1'b1;
        random_faces(40);
        wait_quiet();
      end
      random_faces(phase == 0 ? 130 : 150);
      wait_quiet();
    end

    $display("vertices %0d, triangles checked %0d (%0d degenerate), long hold-offs %0d",
             sb.vertices_in, sb.tris_checked, sb.degen_checked, long_holds);
    $display("limits covered: 0, 65535, 1 and %0d", limits[2]);
    if (sb.errors == 0 && sb.pending_tris.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

`default_nettype wire

// ===== files.f =====
rtl/pfn_pkg.sv
rtl/pfn_if.sv
rtl/pfn_serial_mul.sv
rtl/pfn_isqrt.sv
rtl/pfn_divider.sv
rtl/polygon_fan_flat_normal_top.sv
tb/sv/polygon_fan_flat_normal_top_tb.sv
